FILE: rtl/core/lens_park_ramp_generator_macros.svh
// Assertion macros shared by the lens park ramp generator RTL.
`ifndef LENS_PARK_RAMP_GENERATOR_MACROS_SVH
`define LENS_PARK_RAMP_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPRG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lprg_pkg.sv
// Shared types and constants for the lens park ramp generator.
package lprg_pkg;

    localparam int DAC_BITS = 10;

    localparam logic [DAC_BITS-1:0] FALLBACK_STEP = DAC_BITS'(10);
    localparam logic [DAC_BITS-1:0] KNEE_RST0     = DAC_BITS'(300);
    localparam logic [DAC_BITS-1:0] STEP_RST0     = DAC_BITS'(60);
    localparam logic [DAC_BITS-1:0] KNEE_RST1     = DAC_BITS'(200);
    localparam logic [DAC_BITS-1:0] STEP_RST1     = DAC_BITS'(40);
    localparam logic [DAC_BITS-1:0] PARK_POS_RST  = DAC_BITS'(100);

    typedef enum logic [1:0] {
        CMD_EDIT  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_IDLE        = 3'd0,
        STAT_RUNNING     = 3'd1,
        STAT_DONE        = 3'd2,
        STAT_ABORT_USER  = 3'd3,
        STAT_ABORT_WRITE = 3'd4
    } status_t;

    typedef enum logic {
        REG_PARK_POSITION = 1'b0,
        REG_PARK_ENABLE   = 1'b1
    } reg_index_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [DAC_BITS-1:0] knee_point;
        logic [DAC_BITS-1:0] step_size;
        logic [DAC_BITS-1:0] start_position;
        logic                other_users;
        logic                last_write_failed;
    } item_t;

    typedef struct packed {
        logic [DAC_BITS-1:0] dac_code;
        logic                dac_write;
        status_t             park_status;
    } result_t;

    typedef struct packed {
        logic                clear;
        logic                insert;
        logic [DAC_BITS-1:0] knee;
        logic [DAC_BITS-1:0] step;
    } tbl_edit_t;

    typedef struct packed {
        logic                ge;
        logic                gt;
        logic [DAC_BITS-1:0] diff;
    } alu_res_t;

endpackage

FILE: rtl/core/lprg_alu.sv
// Shared subtract and compare unit: a >= b, a > b and the saturated a - b.
module lprg_alu import lprg_pkg::*; (
    input  logic [DAC_BITS-1:0] op_a,
    input  logic [DAC_BITS-1:0] op_b,
    output alu_res_t            res
);

    logic [DAC_BITS:0] wide_diff;

    assign wide_diff = {1'b0, op_a} - {1'b0, op_b};

    always_comb begin
        res.ge   = ~wide_diff[DAC_BITS];
        res.gt   = ~wide_diff[DAC_BITS] && (wide_diff[DAC_BITS-1:0] != '0);
        res.diff = res.gt ? wide_diff[DAC_BITS-1:0] : '0;
    end

endmodule

FILE: rtl/core/lprg_table.sv
// Stage table held in registers, sorted by descending knee, with clear and insert.
module lprg_table import lprg_pkg::*; #(
    parameter int TABLE_DEPTH = 10,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IDX_W-1:0]    idx,
    input  tbl_edit_t           edit,
    output logic [DAC_BITS-1:0] rd_knee,
    output logic [DAC_BITS-1:0] rd_step
);

    logic [DAC_BITS-1:0] knee_reg [TABLE_DEPTH];
    logic [DAC_BITS-1:0] step_reg [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
        localparam logic [DAC_BITS-1:0] KNEE_INIT =
            (g == 0) ? KNEE_RST0 : ((g == 1) ? KNEE_RST1 : '0);
        localparam logic [DAC_BITS-1:0] STEP_INIT =
            (g == 0) ? STEP_RST0 : ((g == 1) ? STEP_RST1 : '0);

        logic [DAC_BITS-1:0] prev_knee;
        logic [DAC_BITS-1:0] prev_step;

        if (g == 0) begin : g_head
            assign prev_knee = edit.knee;
            assign prev_step = edit.step;
        end else begin : g_body
            assign prev_knee = knee_reg[g-1];
            assign prev_step = step_reg[g-1];
        end

        // On insert, entries after the slot move down one place; the last one falls off.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                knee_reg[g] <= KNEE_INIT;
                step_reg[g] <= STEP_INIT;
            end else if (edit.clear) begin
                knee_reg[g] <= '0;
                step_reg[g] <= '0;
            end else if (edit.insert) begin
                if (IDX_W'(g) == idx) begin
                    knee_reg[g] <= edit.knee;
                    step_reg[g] <= edit.step;
                end else if (IDX_W'(g) > idx) begin
                    knee_reg[g] <= prev_knee;
                    step_reg[g] <= prev_step;
                end
            end
        end
    end

    assign rd_knee = knee_reg[idx];
    assign rd_step = step_reg[idx];

endmodule

FILE: rtl/core/lprg_ctrl.sv
// Sequencer that runs each command through the shared unit, one table entry a cycle.
module lprg_ctrl import lprg_pkg::*; #(
    parameter int TABLE_DEPTH = 10,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    input  logic [DAC_BITS-1:0] park_position,
    input  logic                park_enable,
    output logic [IDX_W-1:0]    tbl_idx,
    output tbl_edit_t           tbl_edit,
    input  logic [DAC_BITS-1:0] tbl_knee,
    input  logic [DAC_BITS-1:0] tbl_step,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EXEC     = 7'b0000010,
        ST_WALK     = 7'b0000100,
        ST_FALLBACK = 7'b0001000,
        ST_SUB      = 7'b0010000,
        ST_CHECK    = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DAC_BITS-1:0] lens_reg, lens_next;
    logic                active_reg, active_next;
    logic [DAC_BITS-1:0] sub_step_reg, sub_step_next;
    logic                write_reg, write_next;
    status_t             status_reg, status_next;

    logic [DAC_BITS-1:0] alu_a;
    logic [DAC_BITS-1:0] alu_b;
    alu_res_t            alu;
    logic                idx_last;

    lprg_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu)
    );

    assign idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));

    always_comb begin
        alu_a = lens_reg;
        alu_b = park_position;
        case (state_reg)
            ST_EXEC: begin
                alu_a = item_reg.start_position;
            end
            ST_WALK: begin
                alu_a = (item_reg.cmd == CMD_EDIT) ? item_reg.knee_point : lens_reg;
                alu_b = tbl_knee;
            end
            ST_SUB: begin
                alu_b = sub_step_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        tbl_edit.clear  = (state_reg == ST_EXEC) && (item_reg.cmd == CMD_EDIT) &&
                          (item_reg.knee_point == '0) && (item_reg.step_size == '0);
        // The first stage with a smaller knee than the new one takes the new entry.
        tbl_edit.insert = (state_reg == ST_WALK) && (item_reg.cmd == CMD_EDIT) && alu.gt;
        tbl_edit.knee   = item_reg.knee_point;
        tbl_edit.step   = item_reg.step_size;
    end

    assign tbl_idx = idx_reg;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        lens_next     = lens_reg;
        active_next   = active_reg;
        sub_step_next = sub_step_reg;
        write_next    = write_reg;
        status_next   = status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                write_next  = 1'b0;
                idx_next    = '0;
                status_next = active_reg ? STAT_RUNNING : STAT_IDLE;
                state_next  = ST_FINISH;
                case (item_reg.cmd)
                    CMD_EDIT: begin
                        if (item_reg.step_size != '0) begin
                            state_next = ST_WALK;
                        end
                    end
                    CMD_START: begin
                        lens_next = item_reg.start_position;
                        if (park_enable && alu.gt) begin
                            active_next = 1'b1;
                            status_next = STAT_RUNNING;
                        end else begin
                            active_next = 1'b0;
                            status_next = park_enable ? STAT_DONE : STAT_IDLE;
                        end
                    end
                    CMD_TICK: begin
                        if (!active_reg) begin
                            status_next = STAT_IDLE;
                        end else if (item_reg.last_write_failed) begin
                            active_next = 1'b0;
                            status_next = STAT_ABORT_WRITE;
                        end else if (item_reg.other_users) begin
                            active_next = 1'b0;
                            status_next = STAT_ABORT_USER;
                        end else begin
                            state_next = ST_WALK;
                        end
                    end
                    default: ;
                endcase
            end
            ST_WALK: begin
                if (item_reg.cmd == CMD_EDIT) begin
                    if (alu.gt || idx_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else if (alu.ge && (tbl_step != '0)) begin
                    sub_step_next = tbl_step;
                    state_next    = ST_SUB;
                end else if (idx_last) begin
                    state_next = ST_FALLBACK;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FALLBACK: begin
                // Without a matching stage the fixed step applies only above the park point.
                sub_step_next = alu.gt ? FALLBACK_STEP : '0;
                state_next    = ST_SUB;
            end
            ST_SUB: begin
                lens_next  = alu.diff;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                write_next = 1'b1;
                if (alu.gt) begin
                    status_next = STAT_RUNNING;
                end else begin
                    status_next = STAT_DONE;
                    active_next = 1'b0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            lens_reg   <= '0;
            active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            lens_reg   <= lens_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        sub_step_reg <= sub_step_next;
        write_reg    <= write_next;
        status_reg   <= status_next;
        if ((state_reg == ST_IDLE) && item_valid) begin
            item_reg <= item;
        end
    end

    assign item_ready      = (state_reg == ST_IDLE);
    assign res_valid       = (state_reg == ST_FINISH);
    assign res.dac_code    = lens_reg;
    assign res.dac_write   = write_reg;
    assign res.park_status = status_reg;

endmodule

FILE: rtl/core/lens_park_ramp_generator.sv
// Lens park ramp generator: each input transfer carries one command (table edit, park
// start, ramp tick or no-op) and yields exactly one result transfer with the DAC value,
// a write flag and the park status. Commands run one at a time on a shared
// subtract-compare unit. A table edit or a running ramp tick walks the stage table, one
// entry per cycle through that unit. The result sits in an output register, so the next
// command is accepted while a result still waits to be taken. Configuration writes are
// registered and are seen by a command already in progress.
`include "lens_park_ramp_generator_macros.svh"

module lens_park_ramp_generator import lprg_pkg::*; #(
    parameter int TABLE_DEPTH = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // knee_point[9:0], step_size[19:10], start_position[29:20],
    // other_users[30], last_write_failed[31]
    input  logic [31:0]         s_tdata,
    // cmd[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // dac_code[9:0], dac_write[10], park_status[13:11], zero[15:14]
    output logic [15:0]         m_tdata,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [DAC_BITS-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [DAC_BITS-1:0] park_position_reg;
    logic                park_enable_reg;
    item_t               item;
    logic [IDX_W-1:0]    tbl_idx;
    tbl_edit_t           tbl_edit;
    logic [DAC_BITS-1:0] tbl_knee;
    logic [DAC_BITS-1:0] tbl_step;
    logic                res_valid;
    logic                res_ready;
    result_t             res;
    logic                m_valid_reg;
    result_t             m_res_reg;

    always_comb begin
        item.cmd               = cmd_t'(s_tuser);
        item.knee_point        = s_tdata[9:0];
        item.step_size         = s_tdata[19:10];
        item.start_position    = s_tdata[29:20];
        item.other_users       = s_tdata[30];
        item.last_write_failed = s_tdata[31];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            park_position_reg <= PARK_POS_RST;
            park_enable_reg   <= 1'b1;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_PARK_POSITION: park_position_reg <= cfg_wdata;
                REG_PARK_ENABLE:   park_enable_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    lprg_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .idx     (tbl_idx),
        .edit    (tbl_edit),
        .rd_knee (tbl_knee),
        .rd_step (tbl_step)
    );

    lprg_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_tvalid),
        .item_ready    (s_tready),
        .item          (item),
        .park_position (park_position_reg),
        .park_enable   (park_enable_reg),
        .tbl_idx       (tbl_idx),
        .tbl_edit      (tbl_edit),
        .tbl_knee      (tbl_knee),
        .tbl_step      (tbl_step),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.park_status, m_res_reg.dac_write,
                       m_res_reg.dac_code};

    `LPRG_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while a command was in progress")
    `LPRG_ASSERT_NEXT(a_result_waits, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(res), "pending result lost while the output register was full")
    `LPRG_ASSERT_IMPLY(a_write_status, aclk, aresetn, m_valid_reg && m_res_reg.dac_write, m_res_reg.park_status == STAT_RUNNING || m_res_reg.park_status == STAT_DONE, "DAC write with a status other than running or done")
    `LPRG_ASSERT_IMPLY(a_done_at_park, aclk, aresetn, res_valid && res.dac_write && res.park_status == STAT_DONE, res.dac_code <= park_position_reg, "ramp reported done above the park position")

endmodule
